/* rtl/threshold_bin_histogram_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the threshold bin histogram.
// The macros expect signals named clk and rst in the using module.
// ---------------------------------------------------------------------------
`ifndef THRESHOLD_BIN_HISTOGRAM_ASSERT_SVH
`define THRESHOLD_BIN_HISTOGRAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tbh_pkg.sv */
// ---------------------------------------------------------------------------
// tbh_pkg
// Shared constants and types of the threshold bin histogram.
// ---------------------------------------------------------------------------
package tbh_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int MAX_EDGES   = 7;
  localparam int NUM_BINS    = MAX_EDGES + 1;
  localparam int BIN_W       = $clog2(NUM_BINS);

  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;
  typedef logic [BIN_W-1:0]              bin_t;
  typedef logic [REG_IDX_W-1:0]          reg_idx_t;

  localparam reg_idx_t REG_NUM_EDGES = reg_idx_t'(7);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

/* rtl/threshold_bin_histogram.sv */
// ---------------------------------------------------------------------------
// threshold_bin_histogram
// Histogram with programmable bin edges and a saturating count per bin.
// ---------------------------------------------------------------------------
// Add items are taken one per cycle while no readout is in progress: the bin
// is found by parallel compares against the edges in use, and the count is
// updated by a read-modify-write of the count RAM (registered read), with the
// new value forwarded when consecutive items hit the same bin. A read item
// reports num_edges+1 bins; each bin goes through a RAM read, an output load
// and a hand-off that waits while out_ready is low, and no item is taken until
// the last bin has been delivered, after which all counts read as zero. Counts
// are cleared by per-bin valid flags, so there is no clearing pass after reset.
`include "threshold_bin_histogram_assert.svh"

module threshold_bin_histogram (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [tbh_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [tbh_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [tbh_pkg::VALUE_WIDTH-1:0] sample_value,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tbh_pkg::BIN_W-1:0]           bin_index,
  output logic signed [tbh_pkg::VALUE_WIDTH-1:0] bin_upper_edge,
  output logic                                is_overflow_bin,
  output logic [tbh_pkg::COUNT_WIDTH-1:0]     bin_count,
  output logic                                last_bin
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_LOAD,
    S_OUT
  } state_t;

  state_t state;

  tbh_pkg::value_t edge_reg [tbh_pkg::MAX_EDGES];
  tbh_pkg::bin_t   num_edges;
  tbh_pkg::bin_t   n_use;

  tbh_pkg::bin_t   in_bin;
  logic            found;
  logic            in_fire;
  logic            add_fire;
  logic            rd_fire;

  logic                          s1_valid;
  tbh_pkg::bin_t                 s1_bin;
  logic                          fwd_hit;
  tbh_pkg::count_t               fwd_data;
  tbh_pkg::count_t               base;
  tbh_pkg::count_t               inc;
  logic [tbh_pkg::NUM_BINS-1:0]  cnt_valid;

  tbh_pkg::bin_t   idx;
  tbh_pkg::bin_t   raddr;
  tbh_pkg::count_t rdata;
  logic            clear_all;
  logic            idx_ovf;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tbh_pkg::MAX_EDGES; i++) begin
        edge_reg[i] <= '0;
      end
      num_edges <= '0;
    end else if (cfg_we) begin
      if (cfg_index == tbh_pkg::REG_NUM_EDGES) begin
        num_edges <= cfg_data[tbh_pkg::BIN_W-1:0];
      end else begin
        edge_reg[cfg_index] <= cfg_data[tbh_pkg::VALUE_WIDTH-1:0];
      end
    end
  end

  assign n_use = (num_edges > tbh_pkg::BIN_W'(tbh_pkg::MAX_EDGES))
               ? tbh_pkg::BIN_W'(tbh_pkg::MAX_EDGES) : num_edges;

  // First edge in index order that lies strictly above the sample.
  always_comb begin
    in_bin = n_use;
    found  = 1'b0;
    for (int i = 0; i < tbh_pkg::MAX_EDGES; i++) begin
      if (!found && (tbh_pkg::BIN_W'(i) < n_use) && (sample_value < edge_reg[i])) begin
        in_bin = tbh_pkg::BIN_W'(i);
        found  = 1'b1;
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign add_fire = in_fire && (req_type == tbh_pkg::REQ_ADD);
  assign rd_fire  = in_fire && (req_type == tbh_pkg::REQ_READ);

  assign raddr = (state == S_IDLE) ? in_bin : idx;

  tbh_ram #(
    .WIDTH (tbh_pkg::COUNT_WIDTH),
    .DEPTH (tbh_pkg::NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_bin),
    .wdata (inc),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The RAM returns the old word when the previous item writes the same bin
  // at the edge the read is taken, so that value comes from fwd_data instead.
  assign base = fwd_hit ? fwd_data : (cnt_valid[s1_bin] ? rdata : '0);
  assign inc  = (&base) ? base : base + tbh_pkg::COUNT_WIDTH'(1);

  assign clear_all = out_valid && out_ready && last_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
      cnt_valid <= '0;
    end else begin
      s1_valid <= add_fire;
      fwd_hit  <= add_fire && s1_valid && (s1_bin == in_bin);
      if (clear_all) begin
        cnt_valid <= '0;
      end else if (s1_valid) begin
        cnt_valid[s1_bin] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_bin   <= in_bin;
    fwd_data <= inc;
  end

  assign idx_ovf = (idx == n_use);

  // Readout sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rd_fire) begin
            idx   <= '0;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          bin_index       <= idx;
          bin_upper_edge  <= idx_ovf ? '0 : edge_reg[idx];
          bin_count       <= cnt_valid[idx] ? rdata : '0;
          is_overflow_bin <= idx_ovf;
          last_bin        <= idx_ovf;
          out_valid       <= 1'b1;
          state           <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_bin) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + tbh_pkg::BIN_W'(1);
              state <= S_ADDR;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TBH_ASSERT_SAME(a_no_take_in_readout, out_valid, !in_ready,
                   "item taken while a readout result is pending")
  `TBH_ASSERT_NEXT(a_clear_after_last, clear_all, cnt_valid == '0,
                   "counts not cleared after the last bin")
  `TBH_ASSERT_SAME(a_bin_in_range, out_valid, bin_index <= n_use,
                   "reported bin beyond the overflow bin")
  `TBH_ASSERT_SAME(a_fwd_needs_stage, fwd_hit, s1_valid,
                   "forwarded count without an item in the update stage")

endmodule

/* rtl/tbh_ram.sv */
// ---------------------------------------------------------------------------
// tbh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module tbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* bench/tb_threshold_bin_histogram.sv */
// ---------------------------------------------------------------------------
// tb_threshold_bin_histogram
// Self-checking bench for the threshold bin histogram. Add and read items are
// streamed in with random gaps and random output stalls. A bench-side copy of
// the bin edges and per-bin counts predicts every bin report. Each report is
// compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_threshold_bin_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import tbh_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef value_t edge_set_t [MAX_EDGES];

  typedef struct packed {
    bin_t   index;
    value_t upper_edge;
    logic   overflow;
    count_t count;
    logic   last;
  } bin_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  reg_idx_t              cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_ADD;
  value_t                sample_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  bin_t                  bin_index;
  value_t                bin_upper_edge;
  logic                  is_overflow_bin;
  count_t                bin_count;
  logic                  last_bin;

  // Bench copy of the block's configuration and count store.
  edge_set_t   edge_cfg = '{default: '0};
  logic [2:0]  num_edges_cfg = '0;
  count_t      bin_tally [NUM_BINS] = '{default: '0};
  bin_report_t expected_bins [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;
  int errors = 0;
  int adds_sent = 0;
  int reads_sent = 0;
  int reports_checked = 0;
  int cycle_count = 0;

  threshold_bin_histogram u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .sample_value   (sample_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bin_index      (bin_index),
    .bin_upper_edge (bin_upper_edge),
    .is_overflow_bin(is_overflow_bin),
    .bin_count      (bin_count),
    .last_bin       (last_bin)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Updates the bench histogram for one accepted item and queues the bin
  // reports that a read produces.
  function automatic void predict_request(input logic req, input value_t sample);
    int n;
    int b;
    bin_report_t rep;
    n = (num_edges_cfg > MAX_EDGES) ? MAX_EDGES : int'(num_edges_cfg);
    if (req == REQ_ADD) begin
      b = n;
      // Walk downward so that the lowest matching index wins.
      for (int i = n - 1; i >= 0; i--) begin
        if (sample < edge_cfg[i]) b = i;
      end
      if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1'b1;
    end else begin
      for (int i = 0; i <= n; i++) begin
        rep.index      = bin_t'(i);
        rep.upper_edge = (i == n) ? value_t'(0) : edge_cfg[i];
        rep.overflow   = (i == n);
        rep.count      = bin_tally[i];
        rep.last       = (i == n);
        expected_bins  = {expected_bins, rep};
      end
      foreach (bin_tally[i]) bin_tally[i] = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      out_ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    bin_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected bin report, expected none, got bin %0d count %0h",
                 $time, bin_index, bin_count);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        check_field("bin_index", 32'(want.index), 32'(bin_index));
        check_field("bin_upper_edge", want.upper_edge, bin_upper_edge);
        check_field("is_overflow_bin", 32'(want.overflow), 32'(is_overflow_bin));
        check_field("bin_count", want.count, bin_count);
        check_field("last_bin", 32'(want.last), 32'(last_bin));
        reports_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d bin reports outstanding.",
             cycle_count, expected_bins.size());
    $display("tb_threshold_bin_histogram failed");
    $finish;
  end

  // Presents one item and returns at the edge that accepts it, with valid
  // still high. The caller sends the next item or stops in the same step.
  task automatic send_item(input logic req, input value_t sample);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    sample_value <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req, sample);
    if (req == REQ_ADD) adds_sent++;
    else reads_sent++;
  endtask

  // Stops sending and waits for every pending report, then lets any add
  // still in the count pipeline finish.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every edge register and the edge count. Call only when idle.
  task automatic load_config(input edge_set_t edges, input int unsigned n);
    logic [CFG_DATA_W-1:0] word;
    for (int i = 0; i < MAX_EDGES; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= edges[i];
      @(posedge clk);
    end
    // Upper data bits are don't-care for the edge count; drive them randomly.
    word      = $urandom;
    word[2:0] = n[2:0];
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_EDGES;
    cfg_data  <= word;
    @(posedge clk);
    cfg_we <= 1'b0;
    edge_cfg      = edges;
    num_edges_cfg = n[2:0];
  endtask

  function automatic edge_set_t random_edges(input bit ascending);
    value_t    pool [$];
    edge_set_t e;
    for (int i = 0; i < MAX_EDGES; i++) begin
      case ($urandom_range(0, 2))
        0: pool = {pool, value_t'($urandom)};
        1: pool = {pool, value_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000};
        // Few distinct values, so equal edges show up.
        default: pool = {pool, value_t'($urandom_range(0, 3) * 32'h0001_0000)};
      endcase
    end
    if (ascending) pool.sort();
    foreach (e[i]) e[i] = pool[i];
    return e;
  endfunction

  function automatic value_t pick_sample();
    value_t near;
    near = edge_cfg[$urandom_range(0, MAX_EDGES - 1)];
    case ($urandom_range(0, 5))
      0, 1: return value_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return near + value_t'($urandom_range(0, 4)) - 32'sd2;
    endcase
  endfunction

  task automatic test_reset_state();
    edge_set_t top_edges;
    top_edges = '{default: 32'sh7FFF_FFFF};
    // With no edges in use, every sample lands in the overflow bin.
    send_item(REQ_ADD, 32'sh8000_0000);
    send_item(REQ_ADD, 32'sh7FFF_FFFF);
    send_item(REQ_ADD, 32'sh0000_0000);
    send_item(REQ_READ, value_t'($urandom));
    wait_drain();
    load_config(top_edges, 0);
    send_item(REQ_ADD, 32'sh8000_0000);
    send_item(REQ_READ, value_t'($urandom));
    wait_drain();
  endtask

  task automatic test_edge_boundaries();
    edge_set_t edges;
    edges = '{32'sh8000_0000, -32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0001,
              32'sh0001_0000, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
    load_config(edges, MAX_EDGES);
    send_item(REQ_ADD, 32'sh8000_0000);
    send_item(REQ_ADD, -32'sh0001_0001);
    send_item(REQ_ADD, -32'sh0001_0000);
    send_item(REQ_ADD, -32'sd1);
    send_item(REQ_ADD, 32'sh0000_0000);
    send_item(REQ_ADD, 32'sh0000_0001);
    send_item(REQ_ADD, 32'sh0000_FFFF);
    send_item(REQ_ADD, 32'sh0001_0000);
    send_item(REQ_ADD, 32'sh7FFF_FFFE);
    send_item(REQ_ADD, 32'sh7FFF_FFFF);
    send_item(REQ_ADD, 32'sh7FFF_FFFF);
    send_item(REQ_READ, value_t'($urandom));
    // Counts were cleared by the first read.
    send_item(REQ_READ, value_t'($urandom));
    wait_drain();
  endtask

  task automatic test_unsorted_edges();
    edge_set_t edges;
    edges = '{32'sh0005_0000, -32'sh0001_0000, 32'sh0002_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000};
    load_config(edges, 4);
    send_item(REQ_ADD, 32'sh0006_0000);
    send_item(REQ_ADD, -32'sh0002_0000);
    send_item(REQ_ADD, 32'sh0001_0000);
    send_item(REQ_ADD, 32'sh7FFF_FFFF);
    send_item(REQ_ADD, 32'sh8000_0000);
    send_item(REQ_READ, value_t'($urandom));
    wait_drain();
  endtask

  // Holds the receiver off while items keep coming, so a readout backs up
  // and the block has to stall its input.
  task automatic test_output_hold();
    tx_idle_pct = 0;
    load_config(random_edges(1'b1), 3);
    @(negedge clk);
    rx_hold_cycles = 150;
    @(posedge clk);
    send_item(REQ_ADD, pick_sample());
    send_item(REQ_READ, value_t'($urandom));
    repeat (6) send_item(REQ_ADD, pick_sample());
    send_item(REQ_READ, value_t'($urandom));
    wait_drain();
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int item_goal);
    int sent;
    int burst;
    int unsigned n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < item_goal) begin
      if (sent == 0 || $urandom_range(0, 2) == 0) begin
        wait_drain();
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 1) ? MAX_EDGES : 0;
        else n = $urandom_range(0, MAX_EDGES);
        load_config(random_edges($urandom_range(0, 5) != 0), n);
      end
      burst = $urandom_range(0, 12);
      repeat (burst) send_item(REQ_ADD, pick_sample());
      send_item(REQ_READ, value_t'($urandom));
      sent += burst + 1;
    end
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_edge_boundaries();
    test_unsorted_edges();
    test_output_hold();
    run_random_phase(18, 74, 40);
    run_random_phase(74, 18, 40);
    run_random_phase(0, 0, 40);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_bins.size() != 0) begin
      $display("%0t: %0d bin reports never arrived", $time, expected_bins.size());
      errors++;
    end
    $display("Sent %0d add and %0d read items; %0d bin reports checked, %0d errors.",
             adds_sent, reads_sent, reports_checked, errors);
    $display("Edge sets covered: empty, full, ascending, unsorted, with output stalls.");
    if (errors == 0) begin
      $display("tb_threshold_bin_histogram passed");
    end else begin
      $display("tb_threshold_bin_histogram failed");
    end
    $finish;
  end

endmodule
